/* design/bsi_pkg.sv */
// ----------------------------------------------------------------------------
// bsi_pkg
// Shared constants for the bounded stack with bottom increment: storage
// depth, field widths and operation codes.
// ----------------------------------------------------------------------------
package bsi_pkg;

    localparam int DEPTH  = 1024;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int CAP_W  = 11;
    localparam int WORD_W = 32;
    localparam int MODE_W = 2;
    // width used to compare fill level against the fixed-width fields
    localparam int CMP_W  = (CNT_W > CAP_W) ? CNT_W : CAP_W;

    localparam logic [CAP_W-1:0]  CAP_RESET = CAP_W'(1024);
    localparam logic [WORD_W-1:0] ALL_ONES  = '1;

    localparam logic [MODE_W-1:0] MODE_PUSH = 2'd0;
    localparam logic [MODE_W-1:0] MODE_POP  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_INC  = 2'd2;

endpackage

/* design/bsi_item_if.sv */
// ----------------------------------------------------------------------------
// bsi_item_if
// Input channel: one stack operation per item, valid/ready handshake.
// ----------------------------------------------------------------------------
interface bsi_item_if import bsi_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [MODE_W-1:0]        mode;
    logic signed [WORD_W-1:0] operand_value;
    logic [CAP_W-1:0]         bottom_count;

    modport source (output valid, output mode, output operand_value,
                    output bottom_count, input ready);
    modport sink   (input valid, input mode, input operand_value,
                    input bottom_count, output ready);
endinterface

/* design/bsi_result_if.sv */
// ----------------------------------------------------------------------------
// bsi_result_if
// Output channel: one pop result per item, valid/ready handshake.
// ----------------------------------------------------------------------------
interface bsi_result_if import bsi_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic signed [WORD_W-1:0] popped_value;
    logic                     was_empty;

    modport source (output valid, output popped_value, output was_empty,
                    input ready);
    modport sink   (input valid, input popped_value, input was_empty,
                    output ready);
endinterface

/* design/bounded_stack_with_bottom_increment.sv */
// Timing: push and a register-only increment finish in the accept cycle;
//   pop and a memory increment read the RAM into a register, then update in EXEC.
// Flow: new items wait while a pop or memory increment is in EXEC (single port
//   per RAM); a pop also waits while the previous result is not yet taken.
// Reset: synchronous, active low; fill level 0, capacity 1024, no result
//   pending. The RAMs are not cleared and no entry is read before it is written.
// ----------------------------------------------------------------------------
// bounded_stack_with_bottom_increment
// Bounded LIFO of signed 32-bit words with a lazy increment of the bottom
// entries. Values live in one RAM, pending increments in a second RAM, and the
// pending increment of the top entry is cached in a register.
// ----------------------------------------------------------------------------
module bounded_stack_with_bottom_increment
    import bsi_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [CAP_W-1:0] i_cfg_wdata,
    bsi_item_if.sink         i_item,
    bsi_result_if.source     o_result
);

    // Lazy increment scheme: inc[i] holds an amount that applies to entries
    // 0..i. Increment of the bottom n entries adds to inc[n-1]. A pop returns
    // val[t] + inc[t] and moves inc[t] down into inc[t-1]. inc[top] is kept in
    // r_cache so a pop needs only one read per RAM.
    typedef enum logic {S_IDLE, S_EXEC} t_state;

    t_state                r_state;
    logic [CAP_W-1:0]      r_cap;
    logic [CNT_W-1:0]      r_fill;
    logic [WORD_W-1:0]     r_cache;
    logic                  r_is_pop;
    logic                  r_pop_empty;
    logic                  r_pop_last;
    logic [ADDR_W-1:0]     r_inc_addr;
    logic [WORD_W-1:0]     r_operand;
    logic                  r_out_valid;
    logic [WORD_W-1:0]     r_out_val;
    logic                  r_out_empty;

    // storage
    logic [WORD_W-1:0]     val_mem [DEPTH];
    logic [WORD_W-1:0]     inc_mem [DEPTH];
    logic [WORD_W-1:0]     r_val_rd;
    logic [WORD_W-1:0]     r_inc_rd;

    logic                  accept;
    logic                  out_free;
    logic [CMP_W-1:0]      fill_cmp;
    logic [CMP_W-1:0]      count_cmp;
    logic                  can_push;
    logic [CNT_W-1:0]      inc_n;
    logic                  inc_in_mem;
    logic                  inc_in_cache;

    logic                  val_we;
    logic [ADDR_W-1:0]     val_waddr;
    logic                  inc_we;
    logic [ADDR_W-1:0]     inc_waddr;
    logic [WORD_W-1:0]     inc_wdata;
    logic                  val_re;
    logic [ADDR_W-1:0]     val_raddr;
    logic                  inc_re;
    logic [ADDR_W-1:0]     inc_raddr;

    assign i_item.ready          = (r_state == S_IDLE);
    assign accept                = i_item.valid && i_item.ready;
    assign out_free              = !r_out_valid || o_result.ready;

    assign o_result.valid        = r_out_valid;
    assign o_result.popped_value = r_out_val;
    assign o_result.was_empty    = r_out_empty;

    assign fill_cmp  = CMP_W'(r_fill);
    assign count_cmp = CMP_W'(i_item.bottom_count);
    // effective capacity is min(capacity, DEPTH)
    assign can_push  = (fill_cmp < CMP_W'(r_cap)) && (fill_cmp < CMP_W'(DEPTH));
    assign inc_n     = (count_cmp < fill_cmp) ? CNT_W'(count_cmp) : r_fill;
    // bottom n entries: whole stack goes to the cached top, else to RAM
    assign inc_in_cache = (inc_n != '0) && (inc_n == r_fill);
    assign inc_in_mem   = (inc_n != '0) && (inc_n != r_fill);

    // RAM port control: reads only on accept, writes on push or in EXEC
    always_comb begin
        val_we    = 1'b0;
        val_waddr = r_fill[ADDR_W-1:0];
        inc_we    = 1'b0;
        inc_waddr = r_inc_addr;
        inc_wdata = r_inc_rd + r_operand;
        val_re    = 1'b0;
        val_raddr = ADDR_W'(r_fill - CNT_W'(1));
        inc_re    = 1'b0;
        inc_raddr = ADDR_W'(r_fill - CNT_W'(2));
        if (r_state == S_EXEC) begin
            // write back the updated pending increment
            inc_we = !r_is_pop;
        end else if (accept) begin
            case (i_item.mode)
                MODE_PUSH: begin
                    // store value, spill the cached top increment below it
                    val_we    = can_push;
                    inc_we    = can_push && (r_fill != '0);
                    inc_waddr = ADDR_W'(r_fill - CNT_W'(1));
                    inc_wdata = r_cache;
                end
                MODE_POP: begin
                    val_re = (r_fill != '0);
                    inc_re = (r_fill > CNT_W'(1));
                end
                MODE_INC: begin
                    inc_re    = inc_in_mem;
                    inc_raddr = ADDR_W'(inc_n - CNT_W'(1));
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (val_we) begin
            val_mem[val_waddr] <= i_item.operand_value;
        end
        if (val_re) begin
            r_val_rd <= val_mem[val_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (inc_we) begin
            inc_mem[inc_waddr] <= inc_wdata;
        end
        if (inc_re) begin
            r_inc_rd <= inc_mem[inc_raddr];
        end
    end

    // sequencer, stack pointer and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cap       <= CAP_RESET;
            r_fill      <= '0;
            r_cache     <= '0;
            r_out_valid <= 1'b0;
            r_is_pop    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_cap <= i_cfg_wdata;
            end
            // drop the taken result unless a pop refills the register now
            if (r_out_valid && o_result.ready && !((r_state == S_EXEC) && r_is_pop)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_operand   <= i_item.operand_value;
                        r_inc_addr  <= ADDR_W'(inc_n - CNT_W'(1));
                        r_pop_empty <= (r_fill == '0);
                        r_pop_last  <= (r_fill == CNT_W'(1));
                        case (i_item.mode)
                            MODE_PUSH: begin
                                if (can_push) begin
                                    r_fill  <= r_fill + CNT_W'(1);
                                    r_cache <= '0;
                                end
                            end
                            MODE_POP: begin
                                r_is_pop <= 1'b1;
                                r_state  <= S_EXEC;
                            end
                            MODE_INC: begin
                                if (inc_in_cache) begin
                                    r_cache <= r_cache + i_item.operand_value;
                                end
                                if (inc_in_mem) begin
                                    r_is_pop <= 1'b0;
                                    r_state  <= S_EXEC;
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_EXEC: begin
                    if (!r_is_pop) begin
                        r_state <= S_IDLE;
                    end else if (out_free) begin
                        // hold the pop here until the result register drains
                        r_out_valid <= 1'b1;
                        r_out_empty <= r_pop_empty;
                        r_state     <= S_IDLE;
                        if (r_pop_empty) begin
                            r_out_val <= ALL_ONES;
                        end else begin
                            r_out_val <= r_val_rd + r_cache;
                            r_fill    <= r_fill - CNT_W'(1);
                            r_cache   <= r_pop_last ? '0 : (r_inc_rd + r_cache);
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // fill level never passes the storage depth
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        CMP_W'(r_fill) <= CMP_W'(DEPTH))
        else $error("fill level above depth");

    // a new result appears only out of a pop in EXEC
    a_out_from_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == S_EXEC) && $past(r_is_pop))
        else $error("result without a pop");

    // an empty pop carries all ones
    a_empty_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_empty) |-> (r_out_val == ALL_ONES))
        else $error("empty pop value wrong");

    // fill level drops by exactly one, and only when a pop completes
    a_fill_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && (r_fill < $past(r_fill))) |->
            ((r_fill == $past(r_fill) - CNT_W'(1)) && r_out_valid && !r_out_empty &&
             ($past(r_state) == S_EXEC) && $past(r_is_pop)))
        else $error("bad fill level decrement");

    // no RAM access is issued while an item is in EXEC other than its write
    a_exec_no_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EXEC) |-> (!val_re && !inc_re && !val_we))
        else $error("RAM access overlaps an item in flight");

endmodule
